@@ sv/svm_pkg.sv @@
// Shared types, codes and helper functions for the stack VM core.
// No dependencies; every other file imports this package.
`default_nettype none
package svm_pkg;

    localparam int unsigned DEF_MEM_WORDS   = 32768;
    localparam int unsigned DEF_STACK_DEPTH = 1024;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [1:0] RUN_OK      = 2'd0;
    localparam logic [1:0] RUN_HALT    = 2'd1;
    localparam logic [1:0] RUN_ILLEGAL = 2'd2;

    localparam logic [15:0] REG_BASE  = 16'h8000;
    localparam logic [15:0] REG_END   = 16'h8008;
    localparam logic [15:0] OP_LAST   = 16'd21;
    localparam logic [7:0]  CHAR_QUIT = 8'h51;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [14:0] mem_addr;
        logic [15:0] mem_data;
        logic [7:0]  in_char;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        char_taken;
        logic [14:0] next_pc;
        logic [15:0] read_word;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_HALT = 5'd0,  OP_SET  = 5'd1,  OP_PUSH = 5'd2,  OP_POP  = 5'd3,
        OP_EQ   = 5'd4,  OP_GT   = 5'd5,  OP_JMP  = 5'd6,  OP_JT   = 5'd7,
        OP_JF   = 5'd8,  OP_ADD  = 5'd9,  OP_MULT = 5'd10, OP_MOD  = 5'd11,
        OP_AND  = 5'd12, OP_OR   = 5'd13, OP_NOT  = 5'd14, OP_RMEM = 5'd15,
        OP_WMEM = 5'd16, OP_CALL = 5'd17, OP_RET  = 5'd18, OP_OUT  = 5'd19,
        OP_IN   = 5'd20, OP_NOOP = 5'd21
    } op_e;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RDWAIT, ST_FISSUE, ST_FCAPT, ST_EXEC,
        ST_DIV, ST_MWAIT, ST_SWAIT, ST_DONE
    } state_e;

    // Reduce a 15-bit word address modulo the memory size by scaled subtraction.
    function automatic logic [14:0] wrap_addr(input logic [14:0] a, input int unsigned words);
        logic [20:0] x;
        x = {6'd0, a};
        for (int k = 5; k >= 0; k--) begin
            if (x >= 21'(words << k)) begin
                x = x - 21'(words << k);
            end
        end
        return x[14:0];
    endfunction

    // Instruction length in words, opcode word included.
    function automatic logic [2:0] op_words(input op_e op);
        logic [2:0] n;
        unique case (op)
            OP_HALT, OP_RET, OP_NOOP:                         n = 3'd1;
            OP_PUSH, OP_POP, OP_JMP, OP_CALL, OP_OUT, OP_IN:  n = 3'd2;
            OP_SET, OP_JT, OP_JF, OP_NOT, OP_RMEM, OP_WMEM:   n = 3'd3;
            default:                                          n = 3'd4;
        endcase
        return n;
    endfunction

    // First operand names a destination register.
    function automatic logic op_dest_reg(input op_e op);
        logic d;
        unique case (op)
            OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND,
            OP_OR, OP_NOT, OP_RMEM, OP_IN: d = 1'b1;
            default:                       d = 1'b0;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

@@ sv/svm_pmem.sv @@
// Program memory: one write and one registered read port, addresses wrapped.
// Depends on svm_pkg for wrap_addr.
`default_nettype none
module svm_pmem
    import svm_pkg::*;
#(
    parameter int unsigned MEM_WORDS = DEF_MEM_WORDS
)(
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [14:0] waddr,
    input  wire logic [15:0] wdata,
    input  wire logic [14:0] raddr,
    output logic [15:0]      rdata
);
    localparam int unsigned AW = $clog2(MEM_WORDS);

    logic [15:0]   mem [MEM_WORDS];
    logic [14:0]   widx;
    logic [14:0]   ridx;
    logic [15:0]   rdata_reg;

    assign widx  = wrap_addr(waddr, MEM_WORDS);
    assign ridx  = wrap_addr(raddr, MEM_WORDS);
    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[widx[AW-1:0]] <= wdata;
        end
        rdata_reg <= mem[ridx[AW-1:0]];
    end
endmodule
`default_nettype wire

@@ sv/svm_smem.sv @@
// Return/data stack memory: one write and one registered read port.
// Depends on svm_pkg for the default depth.
`default_nettype none
module svm_smem
    import svm_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
    localparam int unsigned SW = $clog2(STACK_DEPTH)
)(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [SW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [SW-1:0] raddr,
    output logic [15:0]        rdata
);
    logic [15:0] mem [STACK_DEPTH];
    logic [15:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sv/svm_mod.sv @@
// Iterative 16-bit remainder unit, one quotient bit per cycle.
// Depends on svm_pkg only by convention of the project.
`default_nettype none
module svm_mod
    import svm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        go,
    input  wire logic [15:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             fin,
    output logic [15:0]      rem
);
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] dvd_reg, dvd_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [15:0] rem_reg, rem_next;
    logic        run_reg, run_next;
    logic [16:0] trial;

    assign fin = run_reg && (cnt_reg == 5'd16);
    assign rem = rem_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        run_next = run_reg;
        trial    = {rem_reg, dvd_reg[15]};
        if (go)
        begin
            cnt_next = 5'd0;
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = 16'd0;
            run_next = 1'b1;
        end
        else if (fin)
        begin
            run_next = 1'b0;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[15:0];
            end
            dvd_next = {dvd_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 5'd0;
            run_reg <= 1'b0;
            dvd_reg <= 16'd0;
            dvs_reg <= 16'd0;
            rem_reg <= 16'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            run_reg <= run_next;
            dvd_reg <= dvd_next;
            dvs_reg <= dvs_next;
            rem_reg <= rem_next;
        end
    end
endmodule
`default_nettype wire

@@ sv/sixteen_bit_stack_vm_core.sv @@
// Stack VM core. A load writes program memory, a readback waits for the registered
// read; an execute fetches each instruction word (1 to 4 words) in ST_FISSUE and
// ST_FCAPT, then runs ST_EXEC, adding ST_SWAIT for POP and RET, ST_MWAIT for RMEM
// and ST_DIV for MOD; a stopped core answers an execute without fetching. One item
// at a time. done lasts one cycle and the receiver cannot stall. Asynchronous reset
// clears registers, pc, stack count and status; the memories are not cleared.
`default_nettype none
module sixteen_bit_stack_vm_core
    import svm_pkg::*;
#(
    parameter int unsigned MEM_WORDS   = DEF_MEM_WORDS,
    parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire cmd_t cmd,
    output logic      busy,
    output logic      done,
    output rsp_t      result
);
    localparam int unsigned SW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    state_e      state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [14:0] pc_reg, pc_next;
    logic [1:0]  run_reg, run_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [2:0]  nw_reg, nw_next;
    op_e         code_reg, code_next;
    logic [2:0]  dst_reg, dst_next;
    logic [15:0] opv_reg [1:3];
    logic [15:0] opv_next [1:3];
    logic [15:0] regs_reg [8];
    logic [15:0] regs_next [8];
    logic [CW-1:0] sp_reg, sp_next;
    logic        cv_reg, cv_next;
    logic [7:0]  co_reg, co_next;
    logic        ct_reg, ct_next;
    logic [15:0] rw_reg, rw_next;

    logic        pm_we;
    logic [14:0] pm_waddr, pm_raddr;
    logic [15:0] pm_wdata, pm_rdata;
    logic        sk_we;
    logic [SW-1:0] sk_waddr, sk_raddr;
    logic [15:0] sk_wdata, sk_rdata;
    logic        div_go, div_fin;
    logic [15:0] div_rem;

    logic        accept;
    logic [15:0] wd, wd_val, va, vb, vc;
    logic        wd_lit, wd_reg, legal, full;
    logic [CW-1:0] sp_dec;
    logic [31:0] prod;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);

    assign result.status     = run_reg;
    assign result.char_valid = cv_reg;
    assign result.char_out   = co_reg;
    assign result.char_taken = ct_reg;
    assign result.next_pc    = pc_reg;
    assign result.read_word  = rw_reg;

    svm_pmem #(.MEM_WORDS(MEM_WORDS)) u_pmem (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    svm_smem #(.STACK_DEPTH(STACK_DEPTH)) u_smem (
        .clk   (clk),
        .we    (sk_we),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    svm_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (opv_reg[2]),
        .divisor  (opv_reg[3]),
        .fin      (div_fin),
        .rem      (div_rem)
    );

    assign wd     = pm_rdata;
    assign wd_lit = (wd < REG_BASE);
    assign wd_reg = (wd >= REG_BASE) && (wd < REG_END);
    assign wd_val = wd_lit ? wd : regs_reg[wd[2:0]];
    assign va     = opv_reg[1];
    assign vb     = opv_reg[2];
    assign vc     = opv_reg[3];
    assign full   = (sp_reg >= CW'(STACK_DEPTH));
    assign sp_dec = sp_reg - CW'(1);
    assign prod   = {16'd0, vb} * {16'd0, vc};

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pc_next    = pc_reg;
        run_next   = run_reg;
        cnt_next   = cnt_reg;
        nw_next    = nw_reg;
        code_next  = code_reg;
        dst_next   = dst_reg;
        opv_next   = opv_reg;
        regs_next  = regs_reg;
        sp_next    = sp_reg;
        cv_next    = cv_reg;
        co_next    = co_reg;
        ct_next    = ct_reg;
        rw_next    = rw_reg;
        pm_we      = 1'b0;
        pm_waddr   = cmd.mem_addr;
        pm_wdata   = cmd.mem_data;
        pm_raddr   = cmd.mem_addr;
        sk_we      = 1'b0;
        sk_waddr   = sp_reg[SW-1:0];
        sk_wdata   = va;
        sk_raddr   = sp_dec[SW-1:0];
        div_go     = 1'b0;
        legal      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd;
                    cv_next  = 1'b0;
                    co_next  = 8'd0;
                    ct_next  = 1'b0;
                    rw_next  = 16'd0;
                    cnt_next = 2'd0;
                    if (cmd.opcode == CMD_WRITE)
                    begin
                        pm_we      = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (cmd.opcode == CMD_READ)
                    begin
                        state_next = ST_RDWAIT;
                    end
                    else if (cmd.opcode == CMD_EXEC && run_reg == RUN_OK)
                    begin
                        state_next = ST_FISSUE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RDWAIT:
            begin
                rw_next    = pm_rdata;
                state_next = ST_DONE;
            end
            ST_FISSUE:
            begin
                pm_raddr   = pc_reg + 15'(cnt_reg);
                state_next = ST_FCAPT;
            end
            ST_FCAPT:
            begin
                if (cnt_reg == 2'd0)
                begin
                    if (!(wd_lit || wd_reg) || wd_val > OP_LAST)
                    begin
                        run_next   = RUN_ILLEGAL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        code_next = op_e'(wd_val[4:0]);
                        nw_next   = op_words(op_e'(wd_val[4:0]));
                        cnt_next  = 2'd1;
                        state_next = (op_words(op_e'(wd_val[4:0])) == 3'd1) ? ST_EXEC
                                                                           : ST_FISSUE;
                    end
                end
                else
                begin
                    if (cnt_reg == 2'd1 && op_dest_reg(code_reg))
                    begin
                        legal = wd_reg;
                    end
                    else
                    begin
                        legal = wd_lit || wd_reg;
                    end
                    if (!legal)
                    begin
                        run_next   = RUN_ILLEGAL;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        opv_next[cnt_reg] = wd_val;
                        if (cnt_reg == 2'd1)
                        begin
                            dst_next = wd[2:0];
                        end
                        cnt_next   = cnt_reg + 2'd1;
                        state_next = ({1'b0, cnt_reg} + 3'd1 == nw_reg) ? ST_EXEC : ST_FISSUE;
                    end
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (code_reg)
                    OP_HALT: run_next = RUN_HALT;
                    OP_SET:
                    begin
                        regs_next[dst_reg] = vb;
                        pc_next = pc_reg + 15'd3;
                    end
                    OP_PUSH:
                    begin
                        if (full)
                        begin
                            run_next = RUN_ILLEGAL;
                        end
                        else
                        begin
                            sk_we   = 1'b1;
                            sp_next = sp_reg + CW'(1);
                            pc_next = pc_reg + 15'd2;
                        end
                    end
                    OP_POP:
                    begin
                        if (sp_reg == '0)
                        begin
                            run_next = RUN_ILLEGAL;
                        end
                        else
                        begin
                            state_next = ST_SWAIT;
                        end
                    end
                    OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_AND, OP_OR:
                    begin
                        priority case (code_reg)
                            OP_EQ:   regs_next[dst_reg] = {15'd0, vb == vc};
                            OP_GT:   regs_next[dst_reg] = {15'd0, vb > vc};
                            OP_ADD:  regs_next[dst_reg] = {1'b0, 15'(vb[14:0] + vc[14:0])};
                            OP_MULT: regs_next[dst_reg] = {1'b0, prod[14:0]};
                            OP_AND:  regs_next[dst_reg] = vb & vc;
                            default: regs_next[dst_reg] = vb | vc;
                        endcase
                        pc_next = pc_reg + 15'd4;
                    end
                    OP_MOD:
                    begin
                        if (vc == 16'd0)
                        begin
                            run_next = RUN_ILLEGAL;
                        end
                        else
                        begin
                            div_go     = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    OP_JMP: pc_next = va[14:0];
                    OP_JT, OP_JF:
                    begin
                        if ((code_reg == OP_JT) == (va != 16'd0))
                        begin
                            pc_next = vb[14:0];
                        end
                        else
                        begin
                            pc_next = pc_reg + 15'd3;
                        end
                    end
                    OP_NOT:
                    begin
                        regs_next[dst_reg] = {1'b0, ~vb[14:0]};
                        pc_next = pc_reg + 15'd3;
                    end
                    OP_RMEM:
                    begin
                        pm_raddr   = vb[14:0];
                        state_next = ST_MWAIT;
                    end
                    OP_WMEM:
                    begin
                        pm_we    = 1'b1;
                        pm_waddr = va[14:0];
                        pm_wdata = vb;
                        pc_next  = pc_reg + 15'd3;
                    end
                    OP_CALL:
                    begin
                        if (full)
                        begin
                            run_next = RUN_ILLEGAL;
                        end
                        else
                        begin
                            sk_we    = 1'b1;
                            sk_wdata = {1'b0, 15'(pc_reg + 15'd2)};
                            sp_next  = sp_reg + CW'(1);
                            pc_next  = va[14:0];
                        end
                    end
                    OP_RET:
                    begin
                        if (sp_reg == '0)
                        begin
                            run_next = RUN_HALT;
                        end
                        else
                        begin
                            state_next = ST_SWAIT;
                        end
                    end
                    OP_OUT:
                    begin
                        cv_next = 1'b1;
                        co_next = va[7:0];
                        pc_next = pc_reg + 15'd2;
                    end
                    OP_IN:
                    begin
                        ct_next = 1'b1;
                        if (cmd_reg.in_char == CHAR_QUIT)
                        begin
                            run_next = RUN_HALT;
                        end
                        else
                        begin
                            regs_next[dst_reg] = {8'd0, cmd_reg.in_char};
                            pc_next = pc_reg + 15'd2;
                        end
                    end
                    OP_NOOP: pc_next = pc_reg + 15'd1;
                    default: run_next = RUN_ILLEGAL;
                endcase
            end
            ST_DIV:
            begin
                if (div_fin)
                begin
                    regs_next[dst_reg] = div_rem;
                    pc_next    = pc_reg + 15'd4;
                    state_next = ST_DONE;
                end
            end
            ST_MWAIT:
            begin
                regs_next[dst_reg] = pm_rdata;
                pc_next    = pc_reg + 15'd3;
                state_next = ST_DONE;
            end
            ST_SWAIT:
            begin
                // stack read issued in execute; drop the top entry
                sp_next = sp_dec;
                if (code_reg == OP_POP)
                begin
                    regs_next[dst_reg] = sk_rdata;
                    pc_next = pc_reg + 15'd2;
                end
                else
                begin
                    pc_next = sk_rdata[14:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= 15'd0;
            run_reg   <= RUN_OK;
            sp_reg    <= '0;
            cnt_reg   <= 2'd0;
            nw_reg    <= 3'd0;
            code_reg  <= OP_HALT;
            dst_reg   <= 3'd0;
            cv_reg    <= 1'b0;
            co_reg    <= 8'd0;
            ct_reg    <= 1'b0;
            rw_reg    <= 16'd0;
            cmd_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= 16'd0;
            end
            for (int i = 1; i <= 3; i++)
            begin
                opv_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            run_reg   <= run_next;
            sp_reg    <= sp_next;
            cnt_reg   <= cnt_next;
            nw_reg    <= nw_next;
            code_reg  <= code_next;
            dst_reg   <= dst_next;
            cv_reg    <= cv_next;
            co_reg    <= co_next;
            ct_reg    <= ct_next;
            rw_reg    <= rw_next;
            cmd_reg   <= cmd_next;
            regs_reg  <= regs_next;
            opv_reg   <= opv_next;
        end
    end

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("transfer accepted but core not busy");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg != RUN_OK |=> run_reg == $past(run_reg))
        else $error("stopped status changed");
endmodule
`default_nettype wire
